// ===== sv/yuyv_nv12_pkg.sv =====
// Package for the YUYV 4:2:2 to NV12 converter: beat payload structs,
// register indexes and sizing constants. No dependencies.
`timescale 1ns / 1ps

package yuyv_nv12_pkg;

  localparam int MAX_PAIRS = 2048;
  localparam int SLOT_W    = $clog2(MAX_PAIRS);
  localparam int ADDR_W    = 25;
  localparam int PADDR_W   = 4;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [11:0] WIDTH_MAX  = 12'd2048;
  localparam logic [12:0] HEIGHT_MAX = 13'd4096;

  typedef enum logic [1:0] {
    REG_WIDTH_PAIRS   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_LUMA_STRIDE   = 2'd2,
    REG_CHROMA_STRIDE = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    PLANE_LUMA   = 1'b0,
    PLANE_CHROMA = 1'b1
  } plane_t;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } in_item_t;

  typedef struct packed {
    logic              plane;
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        first_byte;
    logic [7:0]        second_byte;
    logic              last_of_run;
  } out_item_t;

endpackage

// ===== sv/yuyv_to_nv12_converter_top.sv =====
// Top level of the YUYV 4:2:2 to NV12 converter: counters, chroma line store,
// address generation and the result queue. Depends on yuyv_nv12_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall / in_data): one YUYV pixel pair per
//   beat, raster order. Output channel (out_valid / out_stall / out_data):
//   one plane write per beat. Every pair gives a luma write; pairs on odd
//   rows also give a chroma write (averages of this row's and the row
//   above's U and V), which follows the luma write and carries last_of_run.
//   Path: a result passes the stage register, which also receives the line
//   store read, and then the result queue register before it is offered.
//   Throughput: one pair per cycle on even rows while out_stall is low,
//   set by the single read or write to the line store per pair. On odd
//   rows each pair yields two output beats, so the output port sets the
//   rate.
//   Config: APB-style, four registers at byte addresses 0, 4, 8, 12; write
//   only while idle. pready is tied high.
//   Reset: counters, stage valid and queue are cleared, registers return
//   to 320/480/640/640. The line store is not cleared; each entry is
//   written on an even row before the odd row below reads it.
//   Stall: when out_stall holds, the four-entry queue fills, the stage
//   register holds its pair and in_stall rises; nothing is dropped.
module yuyv_to_nv12_converter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  yuyv_nv12_pkg::in_item_t           in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output yuyv_nv12_pkg::out_item_t          out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [yuyv_nv12_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import yuyv_nv12_pkg::*;

  // Configuration registers
  logic [11:0] width_pairs_r;
  logic [12:0] frame_height_r;
  logic [13:0] luma_stride_r;
  logic [13:0] chroma_stride_r;
  cfg_reg_t    cfg_sel;
  logic        cfg_wr;

  // Position counters
  logic [10:0] col_r, col_nxt;
  logic [11:0] row_r, row_nxt;
  logic [11:0] eff_width;
  logic [12:0] eff_height;

  // Stage register: one pair, its addresses and the line store read
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_odd_r;
  in_item_t          s1_item_r;
  logic [ADDR_W-1:0] s1_laddr_r;
  logic [ADDR_W-1:0] s1_caddr_r;
  logic [15:0]       line_rd_r;

  // Line store: U in the low byte, V in the high byte
  logic [15:0] line_mem [MAX_PAIRS];
  logic [SLOT_W-1:0] slot;

  // Result queue
  out_item_t           q_mem [QDEPTH];
  logic [QPTR_W-1:0]   q_wr_r, q_rd_r;
  logic [QPTR_W:0]     q_cnt_r;
  logic [QPTR_W-1:0]   q_wr_p1;
  logic [1:0]          push_n;
  logic                pop;
  out_item_t           luma_res, chroma_res;

  logic              in_acc;
  logic              s1_drain;
  logic              odd;
  logic [ADDR_W-1:0] luma_prod;
  logic [ADDR_W-1:0] chroma_prod;
  logic [ADDR_W-1:0] col_term;
  logic [8:0]        sum_u, sum_v;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_pairs_r   <= 12'd320;
      frame_height_r  <= 13'd480;
      luma_stride_r   <= 14'd640;
      chroma_stride_r <= 14'd640;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_WIDTH_PAIRS:   width_pairs_r   <= pwdata[11:0];
        REG_FRAME_HEIGHT:  frame_height_r  <= pwdata[12:0];
        REG_LUMA_STRIDE:   luma_stride_r   <= pwdata[13:0];
        REG_CHROMA_STRIDE: chroma_stride_r <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_WIDTH_PAIRS:   prdata = {20'd0, width_pairs_r};
      REG_FRAME_HEIGHT:  prdata = {19'd0, frame_height_r};
      REG_LUMA_STRIDE:   prdata = {18'd0, luma_stride_r};
      REG_CHROMA_STRIDE: prdata = {18'd0, chroma_stride_r};
      default:           prdata = 32'd0;
    endcase
  end

  // ---------------- accept and position ----------------
  // Drain the stage only when the queue has room for two beats.
  assign s1_drain = s1_valid_r && (q_cnt_r <= (QPTR_W + 1)'(QDEPTH - 2));
  assign in_stall = s1_valid_r && !s1_drain;
  assign in_acc   = in_valid && !in_stall;
  assign odd      = row_r[0];
  assign slot     = col_r[SLOT_W-1:0];

  // Zero sizes act as one, oversize saturates.
  always_comb begin
    if (width_pairs_r == 12'd0)          eff_width = 12'd1;
    else if (width_pairs_r > WIDTH_MAX)  eff_width = WIDTH_MAX;
    else                                 eff_width = width_pairs_r;
    if (frame_height_r == 13'd0)          eff_height = 13'd1;
    else if (frame_height_r > HEIGHT_MAX) eff_height = HEIGHT_MAX;
    else                                  eff_height = frame_height_r;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if ({1'b0, col_r} + 12'd1 >= eff_width) begin
        col_nxt = 11'd0;
        if ({1'b0, row_r} + 13'd1 >= eff_height) row_nxt = 12'd0;
        else                                     row_nxt = row_r + 12'd1;
      end else begin
        col_nxt = col_r + 11'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 11'd0;
      row_r <= 12'd0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- address generation ----------------
  assign luma_prod   = ADDR_W'(luma_stride_r) * ADDR_W'(row_r);
  assign chroma_prod = ADDR_W'(chroma_stride_r) * ADDR_W'(row_r[11:1]);
  assign col_term    = ADDR_W'({col_r, 1'b0});

  // ---------------- line store ----------------
  // Even rows write, odd rows read; the even write to a slot lands before the
  // odd read of it, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (in_acc && !odd) begin
      line_mem[slot] <= {in_data.chroma_red, in_data.chroma_blue};
    end
    if (in_acc && odd) begin
      line_rd_r <= line_mem[slot];
    end
  end

  // ---------------- stage register ----------------
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc)        s1_valid_nxt = 1'b1;
    else if (s1_drain) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r  <= in_data;
      s1_odd_r   <= odd;
      s1_laddr_r <= luma_prod + col_term;
      s1_caddr_r <= chroma_prod + col_term;
    end
  end

  // ---------------- result formation ----------------
  assign sum_u = {1'b0, line_rd_r[7:0]}  + {1'b0, s1_item_r.chroma_blue};
  assign sum_v = {1'b0, line_rd_r[15:8]} + {1'b0, s1_item_r.chroma_red};

  always_comb begin
    luma_res.plane          = PLANE_LUMA;
    luma_res.byte_address   = s1_laddr_r;
    luma_res.first_byte     = s1_item_r.luma_first;
    luma_res.second_byte    = s1_item_r.luma_second;
    luma_res.last_of_run    = !s1_odd_r;
    chroma_res.plane        = PLANE_CHROMA;
    chroma_res.byte_address = s1_caddr_r;
    chroma_res.first_byte   = sum_u[8:1];
    chroma_res.second_byte  = sum_v[8:1];
    chroma_res.last_of_run  = 1'b1;
  end

  // ---------------- result queue ----------------
  assign push_n    = !s1_drain ? 2'd0 : (s1_odd_r ? 2'd2 : 2'd1);
  assign pop       = out_valid && !out_stall;
  assign q_wr_p1   = q_wr_r + QPTR_W'(1);
  assign out_valid = (q_cnt_r != '0);
  assign out_data  = q_mem[q_rd_r];

  always_ff @(posedge clk) begin
    if (s1_drain) begin
      q_mem[q_wr_r] <= luma_res;
      if (s1_odd_r) q_mem[q_wr_p1] <= chroma_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_wr_r  <= q_wr_r + QPTR_W'(push_n);
      if (pop) q_rd_r <= q_rd_r + QPTR_W'(1);
      q_cnt_r <= q_cnt_r + (QPTR_W + 1)'(push_n) - (QPTR_W + 1)'(pop);
    end
  end

`ifndef SYNTHESIS
  // Queue never overflows its four entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= (QPTR_W + 1)'(QDEPTH))
    else $error("result queue overflow");

  // A chroma beat always closes its pair.
  a_chroma_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.plane |-> out_data.last_of_run)
    else $error("chroma beat without last_of_run");

  // An accepted pair is held in the stage on the next cycle.
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted pair lost");

  // An odd-row pair that drains adds two beats unless one leaves.
  a_odd_two_beats: assert property (@(posedge clk) disable iff (!rst_n)
    s1_drain && s1_odd_r && !pop |=> q_cnt_r == $past(q_cnt_r) + (QPTR_W + 1)'(2))
    else $error("odd-row pair did not push two beats");
`endif

endmodule

// ===== sim/yuyv_nv12_checker.sv =====
// Scoreboard for yuyv_to_nv12_converter_top: follows the register port and both
// beat channels, predicts every plane write and compares it field by field.
// Depends on yuyv_nv12_pkg.
`timescale 1ns / 1ps

module yuyv_nv12_checker
  import yuyv_nv12_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  in_item_t           in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending,
  output int                 pairs_seen,
  output int                 luma_seen,
  output int                 chroma_seen,
  output int                 row_now,
  output int                 slots_filled
);

  localparam int PRINT_CAP = 50;

  // Shadow registers and frame position
  logic [11:0] width_reg;
  logic [12:0] height_reg;
  logic [13:0] luma_stride_reg;
  logic [13:0] chroma_stride_reg;
  logic [10:0] column;
  logic [11:0] row;
  logic [15:0] uv_line [MAX_PAIRS];
  int          filled;
  int          mismatches;
  int          beats_out;
  int          pairs_in;
  int          luma_cnt;
  int          chroma_cnt;
  out_item_t   writes_due [$];

  assign fail_count = mismatches;

  function automatic int clamp_size(int raw, int ceiling);
    if (raw == 0) return 1;
    return (raw > ceiling) ? ceiling : raw;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t  write %0d: %s", $time, beats_out, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // Queue the luma write, and on odd rows the averaged chroma write, of one pair.
  function automatic void predict_plane_writes(in_item_t px);
    out_item_t   luma_wr;
    out_item_t   chroma_wr;
    logic [31:0] lin;
    logic [8:0]  u_sum;
    logic [8:0]  v_sum;
    int          ew;
    int          eh;
    int          slot;
    logic        odd_row;
    ew      = clamp_size(int'(width_reg), int'(WIDTH_MAX));
    eh      = clamp_size(int'(height_reg), int'(HEIGHT_MAX));
    slot    = int'(column) % MAX_PAIRS;
    odd_row = row[0];

    lin = 32'(luma_stride_reg) * 32'(row) + 32'({column, 1'b0});
    luma_wr.plane        = PLANE_LUMA;
    luma_wr.byte_address = lin[ADDR_W-1:0];
    luma_wr.first_byte   = px.luma_first;
    luma_wr.second_byte  = px.luma_second;
    luma_wr.last_of_run  = !odd_row;
    writes_due.push_back(luma_wr);

    if (odd_row) begin
      u_sum = {1'b0, uv_line[slot][7:0]} + {1'b0, px.chroma_blue};
      v_sum = {1'b0, uv_line[slot][15:8]} + {1'b0, px.chroma_red};
      lin   = 32'(chroma_stride_reg) * 32'(row[11:1]) + 32'({column, 1'b0});
      chroma_wr.plane        = PLANE_CHROMA;
      chroma_wr.byte_address = lin[ADDR_W-1:0];
      chroma_wr.first_byte   = u_sum[8:1];
      chroma_wr.second_byte  = v_sum[8:1];
      chroma_wr.last_of_run  = 1'b1;
      writes_due.push_back(chroma_wr);
    end else begin
      uv_line[slot] = {px.chroma_red, px.chroma_blue};
      if (int'(column) + 1 > filled) filled = int'(column) + 1;
    end

    // A shrunk size ends the row or frame at the current position.
    if (int'(column) + 1 >= ew) begin
      column = '0;
      row    = (int'(row) + 1 >= eh) ? '0 : row + 12'd1;
    end else begin
      column = column + 11'd1;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      width_reg         = 12'd320;
      height_reg        = 13'd480;
      luma_stride_reg   = 14'd640;
      chroma_stride_reg = 14'd640;
      column            = '0;
      row               = '0;
      writes_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[3:2]))
          REG_WIDTH_PAIRS:   width_reg         = pwdata[11:0];
          REG_FRAME_HEIGHT:  height_reg        = pwdata[12:0];
          REG_LUMA_STRIDE:   luma_stride_reg   = pwdata[13:0];
          REG_CHROMA_STRIDE: chroma_stride_reg = pwdata[13:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_plane_writes(in_data);
        pairs_in++;
      end
      if (out_valid && !out_stall) begin
        beats_out++;
        if (writes_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected write, plane %0d address 0x%0h",
                                  out_data.plane, out_data.byte_address));
        end else begin
          want = writes_due.pop_front();
          check_field("plane", 32'(out_data.plane), 32'(want.plane));
          check_field("byte_address", 32'(out_data.byte_address), 32'(want.byte_address));
          check_field("first_byte", 32'(out_data.first_byte), 32'(want.first_byte));
          check_field("second_byte", 32'(out_data.second_byte), 32'(want.second_byte));
          check_field("last_of_run", 32'(out_data.last_of_run), 32'(want.last_of_run));
          if (want.plane == PLANE_CHROMA) chroma_cnt++;
          else luma_cnt++;
        end
      end
    end
    pending      <= writes_due.size();
    pairs_seen   <= pairs_in;
    luma_seen    <= luma_cnt;
    chroma_seen  <= chroma_cnt;
    row_now      <= int'(row);
    slots_filled <= filled;
  end

endmodule

// ===== sim/tb_yuyv_to_nv12_converter_top.sv =====
// Testbench top for yuyv_to_nv12_converter_top: clock, reset, pixel pair
// stimulus, random output stall, register writes and the verdict.
// Depends on yuyv_nv12_pkg, yuyv_nv12_checker and the block itself.
`timescale 1ns / 1ps

module tb_yuyv_to_nv12_converter_top;
  import yuyv_nv12_pkg::*;

  // No beat for this many cycles means the block has hung. The slowest
  // correct stretch is a short random stall run or the drain at the end.
  localparam int STALL_LIMIT     = 1000;
  // Extra cycles after the final drain leave margin for stray beats.
  localparam int DRAIN_CYCLES    = 20;
  localparam int RANDOM_PHASES   = 8;
  localparam int PAIRS_PER_PHASE = 145;
  localparam int SAT_PAIRS       = 64;
  localparam int STEADY_PHASE    = 2;
  localparam int IDLE_PCT        = 30;

  logic               clk;
  logic               rst_n    = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;
  int pairs_seen;
  int luma_seen;
  int chroma_seen;
  int row_now;
  int slots_filled;

  bit steady         = 1'b0;
  int settings_used  = 0;
  int quiet_cycles   = 0;

  yuyv_to_nv12_converter_top dut (.*);

  yuyv_nv12_checker scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: stall about 30% of cycles, never during the steady phase.
  always @(posedge clk) out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);

  // Watchdog: reset the count on any beat, register access or reset cycle.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("yuyv_to_nv12_converter_top verification failed");
      $finish;
    end
  end

  function automatic in_item_t make_pair(logic [7:0] y0, logic [7:0] u,
                                         logic [7:0] y1, logic [7:0] v);
    return {y0, u, y1, v};
  endfunction

  // Offer one pixel pair, with a random gap ahead of it, and hold it until
  // the block takes it. Returns in the time step of the accepting edge.
  task automatic send_pair(input in_item_t px);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold off until every predicted write has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One register write: setup cycle, then access until pready. psel stays
  // high between back-to-back writes; apply_setting drops it at the end.
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [31:0] width_pairs, input logic [31:0] height,
                               input logic [31:0] luma_stride,
                               input logic [31:0] chroma_stride);
    write_reg(REG_WIDTH_PAIRS, width_pairs);
    write_reg(REG_FRAME_HEIGHT, height);
    write_reg(REG_LUMA_STRIDE, luma_stride);
    write_reg(REG_CHROMA_STRIDE, chroma_stride);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [31:0] pick_stride();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'd16383;
      2:       return $urandom_range(16383);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  initial begin : stimulus
    int w;
    int h;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry (320 x 480, strides 640): six pairs on row 0 with
    // extreme and alternating bytes; these fill line store slots 0..5.
    send_pair(make_pair(8'h00, 8'h00, 8'h00, 8'h00));
    send_pair(make_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_pair(make_pair(8'hAA, 8'h55, 8'hAA, 8'h55));
    send_pair(make_pair(8'h55, 8'hAA, 8'h55, 8'hAA));
    send_pair(make_pair(8'h00, 8'hFF, 8'hFF, 8'h00));
    send_pair(make_pair(8'hFF, 8'h01, 8'h00, 8'hFE));
    drain_results();

    // Shrink the width below the current column: the next pair ends row 0.
    // Odd height 3 leaves a final even row with luma only; luma stride zero
    // and maximum chroma stride.
    apply_setting(4, 3, 0, 16383);
    send_pair(make_pair(8'h01, 8'h80, 8'h02, 8'h7F));
    // Row 1 averages against slots 0..3: truncation, both maxima, odd sums.
    send_pair(make_pair(8'h12, 8'hFF, 8'h34, 8'hFF));
    send_pair(make_pair(8'h56, 8'hFF, 8'h78, 8'hFF));
    send_pair(make_pair(8'h9A, 8'h56, 8'hBC, 8'h54));
    send_pair(make_pair(8'hDE, 8'h00, 8'hF0, 8'h01));
    repeat (4) send_pair(in_item_t'($urandom));
    drain_results();

    // Zero width and height act as one: every pair lands at row 0, column 0.
    apply_setting(0, 0, 16383, 0);
    repeat (2) send_pair(in_item_t'($urandom));
    drain_results();

    // Saturated width and height with maximum strides: pairs run along row 0.
    apply_setting(4095, 8191, 16383, 16383);
    repeat (SAT_PAIRS) send_pair(in_item_t'($urandom));
    drain_results();

    // Narrow to one pair mid row 0: the next pair ends the row, then each
    // row holds a single pair at column 0 of the saturated-height frame.
    apply_setting(1, 8191, 16383, 16383);
    repeat (SAT_PAIRS) send_pair(in_item_t'($urandom));

    // Random geometry per phase, changed wherever the frame position lies.
    // On an odd row the width stays within the line store slots filled so far.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      steady <= (phase == STEADY_PHASE);
      case ($urandom_range(9))
        0:       w = 0;
        1:       w = $urandom_range(13, 48);
        default: w = $urandom_range(1, 12);
      endcase
      if (row_now % 2 == 1 && w > slots_filled) w = $urandom_range(1, slots_filled);
      case ($urandom_range(7))
        0:       h = 0;
        1:       h = 8191;
        default: h = $urandom_range(1, 9);
      endcase
      apply_setting(w, h, pick_stride(), pick_stride());
      repeat (PAIRS_PER_PHASE) send_pair(in_item_t'($urandom));
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d pixel pairs giving %0d luma and %0d chroma writes,",
             pairs_seen, luma_seen, chroma_seen);
    $display("over %0d register settings incl. zero, saturated and wrapping geometry.",
             settings_used);
    if (fail_count == 0) begin
      $display("yuyv_to_nv12_converter_top verification clean");
    end else begin
      $display("yuyv_to_nv12_converter_top verification failed");
    end
    $finish;
  end

endmodule

// ===== yuyv_to_nv12_converter_top.f =====
sv/yuyv_nv12_pkg.sv
sv/yuyv_to_nv12_converter_top.sv
sim/yuyv_nv12_checker.sv
sim/tb_yuyv_to_nv12_converter_top.sv
